// ===== rtl/core/fau_pkg.sv =====
// Shared types and constants for the fraction arithmetic unit.
package fau_pkg;

	localparam int FIELD_W = 16;
	localparam int ACT_W = 3;
	localparam int RES_W = 64;
	localparam int OPERAND_WIDTH_DEF = 16;

	localparam logic [ACT_W-1:0] ACT_ADD = 3'd0;
	localparam logic [ACT_W-1:0] ACT_SUB = 3'd1;
	localparam logic [ACT_W-1:0] ACT_MUL = 3'd2;
	localparam logic [ACT_W-1:0] ACT_DIV = 3'd3;
	localparam logic [ACT_W-1:0] ACT_IMP = 3'd4;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_IMPA,
		OP_IMPB,
		OP_CHECK,
		OP_GCD_DIV,
		OP_GCD_STEP,
		OP_QA_DIV,
		OP_QA,
		OP_QB_DIV,
		OP_QB,
		OP_LCM,
		OP_PA,
		OP_PB,
		OP_SUM,
		OP_MULN,
		OP_MULD,
		OP_DIVN,
		OP_DIVD,
		OP_IMPR,
		OP_PUBLISH
	} op_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_IMPA,
		S_IMPB,
		S_CHECK,
		S_GCD_CHK,
		S_GCD_DIV,
		S_GCD_WAIT,
		S_QA_DIV,
		S_QA_WAIT,
		S_QB_DIV,
		S_QB_WAIT,
		S_LCM,
		S_PA,
		S_PB,
		S_SUM,
		S_MULN,
		S_MULD,
		S_DIVN,
		S_DIVD,
		S_IMPR,
		S_OUT
	} state_t;

	typedef struct packed {
		op_t  op;
		logic in_ready;
	} cmd_t;

	typedef struct packed {
		logic             bad;
		logic [ACT_W-1:0] action;
		logic             y_zero;
		logic             div_done;
		logic             out_busy;
	} stat_t;

endpackage

// ===== rtl/core/fraction_arithmetic_unit.sv =====
// Top level of the fraction arithmetic unit.
// One word at a time: a word is taken only in the idle state, and the next is
// taken once the result has moved into the output register (the output may
// still be waiting to be taken). Multiply and divide need two steps because
// the single multiplier is shared. Add and subtract run Euclid's gcd on the
// denominators through a bit-serial divider of OPERAND_WIDTH+1 bits, then two
// quotient divisions and three multiplier steps; Euclid takes at most 22
// remainder steps at 16-bit operands. A stalled output adds its stall to the
// word behind it. Results are not reduced. A zero denominator in a used
// operand sets bad_operand and returns zero numerator and denominator.
module fraction_arithmetic_unit #(
	parameter int OPERAND_WIDTH = fau_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [fau_pkg::ACT_W-1:0]          action,
	input  logic signed [fau_pkg::FIELD_W-1:0] a_whole,
	input  logic signed [fau_pkg::FIELD_W-1:0] a_num,
	input  logic signed [fau_pkg::FIELD_W-1:0] a_den,
	input  logic signed [fau_pkg::FIELD_W-1:0] b_whole,
	input  logic signed [fau_pkg::FIELD_W-1:0] b_num,
	input  logic signed [fau_pkg::FIELD_W-1:0] b_den,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [fau_pkg::RES_W-1:0]   res_num,
	output logic signed [fau_pkg::RES_W-1:0]   res_den,
	output logic                               bad_operand
);

	fau_pkg::cmd_t  cmd;
	fau_pkg::stat_t stat;

	fau_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.stat    (stat),
		.cmd     (cmd)
	);

	fau_dp #(.W(OPERAND_WIDTH)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.action     (action),
		.a_whole    (a_whole),
		.a_num      (a_num),
		.a_den      (a_den),
		.b_whole    (b_whole),
		.b_num      (b_num),
		.b_den      (b_den),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.res_num    (res_num),
		.res_den    (res_den),
		.bad_operand(bad_operand)
	);

	assign in_ready = cmd.in_ready;

endmodule

// ===== rtl/core/fau_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating remainder.
module fau_div #(
	parameter int DW = fau_pkg::OPERAND_WIDTH_DEF + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [DW-1:0] dividend,
	input  logic signed [DW-1:0] divisor,
	output logic                 done,
	output logic signed [DW-1:0] quot,
	output logic signed [DW-1:0] rem
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] dvs_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic          qneg_q;
	logic          rneg_q;

	logic [DW-1:0] dvd_mag;
	logic [DW-1:0] dvs_mag;
	logic [DW:0]   sh;
	logic [DW:0]   diff;

	assign dvd_mag = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
	assign dvs_mag = divisor[DW-1] ? DW'(-divisor) : DW'(divisor);
	assign sh = {rem_q, quo_q[DW-1]};
	assign diff = sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(DW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= dvs_mag;
			quo_q <= dvd_mag;
			rem_q <= '0;
			qneg_q <= dividend[DW-1] ^ divisor[DW-1];
			rneg_q <= dividend[DW-1];
		end else if (busy_q) begin
			if (!diff[DW]) begin
				rem_q <= diff[DW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= sh[DW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = qneg_q ? -$signed(quo_q) : $signed(quo_q);
	assign rem = rneg_q ? -$signed(rem_q) : $signed(rem_q);

endmodule

// ===== rtl/core/fau_dp.sv =====
// Datapath: operand registers, shared multiplier, divider and output register.
module fau_dp #(
	parameter int W = fau_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fau_pkg::cmd_t                       cmd,
	output fau_pkg::stat_t                      stat,
	input  logic [fau_pkg::ACT_W-1:0]           action,
	input  logic signed [fau_pkg::FIELD_W-1:0]  a_whole,
	input  logic signed [fau_pkg::FIELD_W-1:0]  a_num,
	input  logic signed [fau_pkg::FIELD_W-1:0]  a_den,
	input  logic signed [fau_pkg::FIELD_W-1:0]  b_whole,
	input  logic signed [fau_pkg::FIELD_W-1:0]  b_num,
	input  logic signed [fau_pkg::FIELD_W-1:0]  b_den,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [fau_pkg::RES_W-1:0]    res_num,
	output logic signed [fau_pkg::RES_W-1:0]    res_den,
	output logic                                bad_operand
);

	localparam int IW = 2 * W + 1;
	localparam int MW = 2 * W + 2;
	localparam int PW = 2 * MW;
	localparam int DW = W + 1;
	localparam int RW = fau_pkg::RES_W;

	logic [fau_pkg::ACT_W-1:0] act_q;
	logic signed [W-1:0]  aw_q, anum_q, ad_q, bw_q, bnum_q, bd_q;
	logic signed [IW-1:0] ai_q, bi_q;
	logic signed [DW-1:0] x_q, y_q, qa_q, qb_q;
	logic signed [RW-1:0] num_q, den_q, t_q;
	logic                 bad_q;
	logic signed [RW-1:0] res_num_q, res_den_q;
	logic                 bad_out_q;
	logic                 out_valid_q;

	logic signed [MW-1:0] ma, mb;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] addend;
	logic signed [RW-1:0] prod64;
	logic                 div_start;
	logic signed [DW-1:0] dvd, dvs;
	logic                 div_done;
	logic signed [DW-1:0] div_quot, div_rem;
	logic                 bad_now;

	always_comb begin
		ma = '0;
		mb = '0;
		addend = '0;
		case (cmd.op)
			fau_pkg::OP_IMPA: begin
				ma = MW'(aw_q);
				mb = MW'(ad_q);
				addend = PW'(anum_q);
			end
			fau_pkg::OP_IMPB: begin
				ma = MW'(bw_q);
				mb = MW'(bd_q);
				addend = PW'(bnum_q);
			end
			fau_pkg::OP_LCM: begin
				ma = MW'(qa_q);
				mb = MW'(bd_q);
			end
			fau_pkg::OP_PA: begin
				ma = MW'(qb_q);
				mb = MW'(ai_q);
			end
			fau_pkg::OP_PB: begin
				ma = MW'(qa_q);
				mb = MW'(bi_q);
			end
			fau_pkg::OP_MULN: begin
				ma = MW'(ai_q);
				mb = MW'(bi_q);
			end
			fau_pkg::OP_MULD: begin
				ma = MW'(ad_q);
				mb = MW'(bd_q);
			end
			fau_pkg::OP_DIVN: begin
				ma = MW'(bd_q);
				mb = MW'(ai_q);
			end
			fau_pkg::OP_DIVD: begin
				ma = MW'(ad_q);
				mb = MW'(bi_q);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign prod = ma * mb;
	assign prod64 = RW'(prod);

	always_comb begin
		div_start = 1'b0;
		dvd = x_q;
		dvs = y_q;
		case (cmd.op)
			fau_pkg::OP_GCD_DIV: begin
				div_start = 1'b1;
			end
			fau_pkg::OP_QA_DIV: begin
				div_start = 1'b1;
				dvd = DW'(ad_q);
				dvs = x_q;
			end
			fau_pkg::OP_QB_DIV: begin
				div_start = 1'b1;
				dvd = DW'(bd_q);
				dvs = x_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	fau_div #(.DW(DW)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(dvd),
		.divisor (dvs),
		.done    (div_done),
		.quot    (div_quot),
		.rem     (div_rem)
	);

	always_comb begin
		if (act_q == fau_pkg::ACT_IMP) begin
			bad_now = (ad_q == '0);
		end else if (act_q == fau_pkg::ACT_ADD || act_q == fau_pkg::ACT_SUB ||
				act_q == fau_pkg::ACT_MUL || act_q == fau_pkg::ACT_DIV) begin
			bad_now = (ad_q == '0) || (bd_q == '0);
		end else begin
			bad_now = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			fau_pkg::OP_LOAD: begin
				act_q <= action;
				aw_q <= a_whole[W-1:0];
				anum_q <= a_num[W-1:0];
				ad_q <= a_den[W-1:0];
				bw_q <= b_whole[W-1:0];
				bnum_q <= b_num[W-1:0];
				bd_q <= b_den[W-1:0];
			end
			fau_pkg::OP_IMPA: ai_q <= IW'(prod + addend);
			fau_pkg::OP_IMPB: bi_q <= IW'(prod + addend);
			fau_pkg::OP_CHECK: begin
				num_q <= '0;
				den_q <= '0;
				bad_q <= bad_now;
				x_q <= DW'(ad_q);
				y_q <= DW'(bd_q);
			end
			fau_pkg::OP_GCD_STEP: begin
				x_q <= y_q;
				y_q <= div_rem;
			end
			fau_pkg::OP_QA: qa_q <= div_quot;
			fau_pkg::OP_QB: qb_q <= div_quot;
			fau_pkg::OP_LCM: den_q <= prod64;
			fau_pkg::OP_PA: num_q <= prod64;
			fau_pkg::OP_PB: t_q <= prod64;
			fau_pkg::OP_SUM: begin
				if (act_q == fau_pkg::ACT_ADD) begin
					num_q <= num_q + t_q;
				end else begin
					num_q <= num_q - t_q;
				end
			end
			fau_pkg::OP_MULN, fau_pkg::OP_DIVN: num_q <= prod64;
			fau_pkg::OP_MULD, fau_pkg::OP_DIVD: den_q <= prod64;
			fau_pkg::OP_IMPR: begin
				num_q <= RW'(ai_q);
				den_q <= RW'(ad_q);
			end
			fau_pkg::OP_PUBLISH: begin
				res_num_q <= num_q;
				res_den_q <= den_q;
				bad_out_q <= bad_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == fau_pkg::OP_PUBLISH) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.bad = bad_now;
	assign stat.action = act_q;
	assign stat.y_zero = (y_q == '0);
	assign stat.div_done = div_done;
	assign stat.out_busy = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign res_num = res_num_q;
	assign res_den = res_den_q;
	assign bad_operand = bad_out_q;

endmodule

// ===== rtl/core/fau_ctrl.sv =====
// Controller: sequences the datapath through one operation per word.
module fau_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  fau_pkg::stat_t stat,
	output fau_pkg::cmd_t  cmd
);

	fau_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fau_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			fau_pkg::S_IDLE: if (in_valid) state_nx = fau_pkg::S_IMPA;
			fau_pkg::S_IMPA: state_nx = fau_pkg::S_IMPB;
			fau_pkg::S_IMPB: state_nx = fau_pkg::S_CHECK;
			fau_pkg::S_CHECK: begin
				if (stat.bad) begin
					state_nx = fau_pkg::S_OUT;
				end else begin
					case (stat.action)
						fau_pkg::ACT_ADD, fau_pkg::ACT_SUB: state_nx = fau_pkg::S_GCD_CHK;
						fau_pkg::ACT_MUL: state_nx = fau_pkg::S_MULN;
						fau_pkg::ACT_DIV: state_nx = fau_pkg::S_DIVN;
						fau_pkg::ACT_IMP: state_nx = fau_pkg::S_IMPR;
						default: state_nx = fau_pkg::S_OUT;
					endcase
				end
			end
			fau_pkg::S_GCD_CHK: begin
				state_nx = stat.y_zero ? fau_pkg::S_QA_DIV : fau_pkg::S_GCD_DIV;
			end
			fau_pkg::S_GCD_DIV: state_nx = fau_pkg::S_GCD_WAIT;
			fau_pkg::S_GCD_WAIT: if (stat.div_done) state_nx = fau_pkg::S_GCD_CHK;
			fau_pkg::S_QA_DIV: state_nx = fau_pkg::S_QA_WAIT;
			fau_pkg::S_QA_WAIT: if (stat.div_done) state_nx = fau_pkg::S_QB_DIV;
			fau_pkg::S_QB_DIV: state_nx = fau_pkg::S_QB_WAIT;
			fau_pkg::S_QB_WAIT: if (stat.div_done) state_nx = fau_pkg::S_LCM;
			fau_pkg::S_LCM: state_nx = fau_pkg::S_PA;
			fau_pkg::S_PA: state_nx = fau_pkg::S_PB;
			fau_pkg::S_PB: state_nx = fau_pkg::S_SUM;
			fau_pkg::S_SUM: state_nx = fau_pkg::S_OUT;
			fau_pkg::S_MULN: state_nx = fau_pkg::S_MULD;
			fau_pkg::S_MULD: state_nx = fau_pkg::S_OUT;
			fau_pkg::S_DIVN: state_nx = fau_pkg::S_DIVD;
			fau_pkg::S_DIVD: state_nx = fau_pkg::S_OUT;
			fau_pkg::S_IMPR: state_nx = fau_pkg::S_OUT;
			fau_pkg::S_OUT: if (!stat.out_busy) state_nx = fau_pkg::S_IDLE;
			default: state_nx = fau_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = fau_pkg::OP_NONE;
		cmd.in_ready = 1'b0;
		case (state_q)
			fau_pkg::S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (in_valid) cmd.op = fau_pkg::OP_LOAD;
			end
			fau_pkg::S_IMPA: cmd.op = fau_pkg::OP_IMPA;
			fau_pkg::S_IMPB: cmd.op = fau_pkg::OP_IMPB;
			fau_pkg::S_CHECK: cmd.op = fau_pkg::OP_CHECK;
			fau_pkg::S_GCD_DIV: cmd.op = fau_pkg::OP_GCD_DIV;
			fau_pkg::S_GCD_WAIT: if (stat.div_done) cmd.op = fau_pkg::OP_GCD_STEP;
			fau_pkg::S_QA_DIV: cmd.op = fau_pkg::OP_QA_DIV;
			fau_pkg::S_QA_WAIT: if (stat.div_done) cmd.op = fau_pkg::OP_QA;
			fau_pkg::S_QB_DIV: cmd.op = fau_pkg::OP_QB_DIV;
			fau_pkg::S_QB_WAIT: if (stat.div_done) cmd.op = fau_pkg::OP_QB;
			fau_pkg::S_LCM: cmd.op = fau_pkg::OP_LCM;
			fau_pkg::S_PA: cmd.op = fau_pkg::OP_PA;
			fau_pkg::S_PB: cmd.op = fau_pkg::OP_PB;
			fau_pkg::S_SUM: cmd.op = fau_pkg::OP_SUM;
			fau_pkg::S_MULN: cmd.op = fau_pkg::OP_MULN;
			fau_pkg::S_MULD: cmd.op = fau_pkg::OP_MULD;
			fau_pkg::S_DIVN: cmd.op = fau_pkg::OP_DIVN;
			fau_pkg::S_DIVD: cmd.op = fau_pkg::OP_DIVD;
			fau_pkg::S_IMPR: cmd.op = fau_pkg::OP_IMPR;
			fau_pkg::S_OUT: if (!stat.out_busy) cmd.op = fau_pkg::OP_PUBLISH;
			default: cmd.op = fau_pkg::OP_NONE;
		endcase
	end

endmodule

// ===== rtl/core/fau_checker.sv =====
// Port-level checks for the fraction arithmetic unit, bound to the top level.
module fau_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [fau_pkg::RES_W-1:0]        res_num,
	input logic [fau_pkg::RES_W-1:0]        res_den,
	input logic                             bad_operand
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(res_num) && $stable(res_den)
			&& $stable(bad_operand))
		else $error("result word changed while stalled");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_operand |-> res_num == '0 && res_den == '0)
		else $error("bad operand word carries nonzero result");

	// one word in flight: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word accepted without processing");

	// a result does not appear right after an accept made with the output empty
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result appeared too early");

endmodule

bind fraction_arithmetic_unit fau_checker u_fau_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.res_num    (res_num),
	.res_den    (res_den),
	.bad_operand(bad_operand)
);

// ===== tb/fraction_arithmetic_unit_test.sv =====
// Testbench for fraction_arithmetic_unit: a queue-fed driver, a predictor and a monitor that checks every result word.
`timescale 1ns / 1ps

module fraction_arithmetic_unit_test;

	localparam int LIMIT_CYCLES = 3000000;
	localparam int RANDOM_PER_PHASE = 200;
	localparam int TAIL_CYCLES = 1200;

	typedef struct {
		logic [fau_pkg::ACT_W-1:0]          action;
		logic signed [fau_pkg::FIELD_W-1:0] a_whole, a_num, a_den, b_whole, b_num, b_den;
	} fraction_word_t;

	typedef struct {
		logic signed [fau_pkg::RES_W-1:0] num;
		logic signed [fau_pkg::RES_W-1:0] den;
		logic                             bad;
	} fraction_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [fau_pkg::ACT_W-1:0] action = '0;
	logic signed [fau_pkg::FIELD_W-1:0] a_whole = '0, a_num = '0, a_den = '0;
	logic signed [fau_pkg::FIELD_W-1:0] b_whole = '0, b_num = '0, b_den = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [fau_pkg::RES_W-1:0] res_num, res_den;
	logic bad_operand;

	fraction_word_t   pending_words[$];
	fraction_result_t expected_results[$];
	fraction_word_t   on_port;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;
	int results_seen = 0;
	int cycles = 0;
	bit running = 1'b0;
	bit hold_request = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;

	fraction_arithmetic_unit uut (.*);

	always #10 clk = ~clk;

	function automatic longint euclid_gcd(longint x, longint y);
		longint r;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		return x;
	endfunction

	function automatic fraction_result_t predict_fraction(fraction_word_t w);
		fraction_result_t r;
		longint an, ad, bn, bd, g, l, pa, pb;
		r.num = 0;
		r.den = 0;
		r.bad = 1'b0;
		ad = longint'(w.a_den);
		bd = longint'(w.b_den);
		an = longint'(w.a_whole) * ad + longint'(w.a_num);
		bn = longint'(w.b_whole) * bd + longint'(w.b_num);
		if (w.action == fau_pkg::ACT_ADD || w.action == fau_pkg::ACT_SUB ||
				w.action == fau_pkg::ACT_MUL || w.action == fau_pkg::ACT_DIV) begin
			if (ad == 0 || bd == 0) begin
				r.bad = 1'b1;
			end else if (w.action == fau_pkg::ACT_ADD || w.action == fau_pkg::ACT_SUB) begin
				g = euclid_gcd(ad, bd);
				l = (ad * bd) / g;
				pa = (l / ad) * an;
				pb = (l / bd) * bn;
				r.den = l;
				r.num = (w.action == fau_pkg::ACT_ADD) ? pa + pb : pa - pb;
			end else if (w.action == fau_pkg::ACT_MUL) begin
				r.num = an * bn;
				r.den = ad * bd;
			end else begin
				r.num = bd * an;
				r.den = ad * bn;
			end
		end else if (w.action == fau_pkg::ACT_IMP) begin
			if (ad == 0) begin
				r.bad = 1'b1;
			end else begin
				r.num = an;
				r.den = ad;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("error: %s got %0d want %0d (result %0d)", what, got, want, results_seen);
		errors++;
	endtask

	// driver
	always @(posedge clk) begin
		if (running) begin
			if (in_valid && in_ready)
				expected_results.push_back(predict_fraction(on_port));
			if (!in_valid || in_ready) begin
				if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					on_port = pending_words.pop_front();
					action <= on_port.action;
					a_whole <= on_port.a_whole;
					a_num <= on_port.a_num;
					a_den <= on_port.a_den;
					b_whole <= on_port.b_whole;
					b_num <= on_port.b_num;
					b_den <= on_port.b_den;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off counter
	always @(posedge clk) begin
		if (running) begin
			if (hold_request && !hold_done) begin
				hold_done <= 1'b1;
				hold_left <= 3000;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
			end
		end
	end

	// monitor and receiver
	always @(posedge clk) begin
		fraction_result_t want;
		if (running) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected word, res_num", res_num, 0);
				end else begin
					want = expected_results.pop_front();
					if (res_num !== want.num)
						report_mismatch("res_num", res_num, want.num);
					if (res_den !== want.den)
						report_mismatch("res_den", res_den, want.den);
					if (bad_operand !== want.bad)
						report_mismatch("bad_operand", bad_operand, want.bad);
				end
			end
			if ((hold_request && !hold_done) || hold_left > 0) begin
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic signed [fau_pkg::FIELD_W-1:0] rand_field();
		case ($urandom_range(3))
			0: return fau_pkg::FIELD_W'($urandom);
			1: return fau_pkg::FIELD_W'(int'($urandom_range(40)) - 20);
			2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			default: return fau_pkg::FIELD_W'($urandom_range(300, 1));
		endcase
	endfunction

	function automatic logic signed [fau_pkg::FIELD_W-1:0] rand_den();
		if ($urandom_range(19) == 0)
			return '0;
		return rand_field();
	endfunction

	task automatic queue_word(logic [fau_pkg::ACT_W-1:0] act, int aw, int an, int ad,
			int bw, int bn, int bd);
		fraction_word_t w;
		w.action = act;
		w.a_whole = fau_pkg::FIELD_W'(aw);
		w.a_num = fau_pkg::FIELD_W'(an);
		w.a_den = fau_pkg::FIELD_W'(ad);
		w.b_whole = fau_pkg::FIELD_W'(bw);
		w.b_num = fau_pkg::FIELD_W'(bn);
		w.b_den = fau_pkg::FIELD_W'(bd);
		pending_words.push_back(w);
	endtask

	task automatic drain();
		while (pending_words.size() > 0 || in_valid || expected_results.size() > 0 ||
				hold_left > 0)
			@(posedge clk);
	endtask

	initial begin
		int idle_send[4] = '{0, 77, 0, 20};
		int idle_recv[4] = '{0, 0, 77, 20};
		fraction_word_t w;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		running <= 1'b1;

		// directed: extremes, every action, zero denominators, unused b, bad codes
		queue_word(fau_pkg::ACT_ADD, 1, 1, 2, 2, 1, 3);
		queue_word(fau_pkg::ACT_SUB, 1, 1, 4, 0, 3, 6);
		queue_word(fau_pkg::ACT_MUL, -3, 2, 5, 4, -1, 7);
		queue_word(fau_pkg::ACT_DIV, 2, 1, 3, 1, 1, 2);
		queue_word(fau_pkg::ACT_IMP, 5, 3, 4, 0, 0, 0);
		queue_word(fau_pkg::ACT_ADD, -32768, -32768, -32768, -32768, -32768, -32768);
		queue_word(fau_pkg::ACT_SUB, 32767, 32767, 32767, 32767, 32767, 32767);
		queue_word(fau_pkg::ACT_MUL, -32768, 32767, -32768, 32767, -32768, 32767);
		queue_word(fau_pkg::ACT_DIV, 32767, -32768, 32767, -32768, 32767, -32768);
		queue_word(fau_pkg::ACT_ADD, 32767, -32768, 32749, -32768, 32767, 32719);
		queue_word(fau_pkg::ACT_SUB, 0, 7, -6, 0, 5, 9);
		queue_word(fau_pkg::ACT_ADD, 1, 1, -4, 1, 1, -6);
		queue_word(fau_pkg::ACT_ADD, 1, 1, 0, 1, 1, 3);
		queue_word(fau_pkg::ACT_SUB, 1, 1, 3, 1, 1, 0);
		queue_word(fau_pkg::ACT_MUL, 0, 0, 0, 0, 0, 0);
		queue_word(fau_pkg::ACT_DIV, 1, 1, 2, 0, 0, 5);
		queue_word(fau_pkg::ACT_DIV, 2, -6, 3, 0, 1, 0);
		queue_word(fau_pkg::ACT_IMP, 1, 1, 0, 1, 1, 1);
		queue_word(fau_pkg::ACT_IMP, -32768, 32767, -32768, 3, 3, 0);
		queue_word(3'd5, 1, 2, 3, 4, 5, 6);
		queue_word(3'd6, 1, 2, 0, 4, 5, 0);
		queue_word(3'd7, -1, -1, -1, -1, -1, -1);
		queue_word(fau_pkg::ACT_ADD, 0, 0, 1, 0, 0, 1);
		drain();

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_send[p];
			recv_stall_pct = idle_recv[p];
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				w.action = ($urandom_range(9) == 0) ?
					fau_pkg::ACT_W'($urandom_range(7, 5)) :
					fau_pkg::ACT_W'($urandom_range(4));
				w.a_whole = rand_field();
				w.a_num = rand_field();
				w.a_den = rand_den();
				w.b_whole = rand_field();
				w.b_num = rand_field();
				w.b_den = rand_den();
				pending_words.push_back(w);
			end
			// long receiver hold-off while words keep coming: input must back up
			if (p == 0)
				hold_request = 1'b1;
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d result words over four idle/stall phases and one long hold-off",
			results_seen);
		$display("all actions, undefined codes, zero denominators and field extremes driven");
		if (errors == 0 && expected_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches, %0d words outstanding", errors, expected_results.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== fraction_arithmetic_unit.f =====
rtl/core/fau_pkg.sv
rtl/core/fau_div.sv
rtl/core/fau_dp.sv
rtl/core/fau_ctrl.sv
rtl/core/fraction_arithmetic_unit.sv
rtl/core/fau_checker.sv
tb/fraction_arithmetic_unit_test.sv
